// ===== rtl/sql_wire_message_tracker_core_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef SQL_WIRE_MESSAGE_TRACKER_CORE_MACROS_SVH
`define SQL_WIRE_MESSAGE_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/swmt_pkg.sv =====
package swmt_pkg;

   localparam int TOTAL_BITS = 32;

   // Header position codes of one direction's framer.
   localparam logic [2:0] HDR_KIND      = 3'd0;
   localparam logic [2:0] HDR_LEN_FIRST = 3'd1;
   localparam logic [2:0] HDR_LEN_LAST  = 3'd4;
   localparam logic [2:0] HDR_BODY      = 3'd5;

   localparam logic [31:0] MIN_LEN = 32'd4;

   // Message kinds and status codes.
   localparam logic [7:0] KIND_QUERY   = 8'h51;
   localparam logic [7:0] KIND_EXECUTE = 8'h45;
   localparam logic [7:0] KIND_STATUS  = 8'h5A;
   localparam logic [7:0] STATUS_IDLE  = 8'h49;

   typedef struct packed {
      logic start;
      logic last;
      logic err;
      logic body;
      logic to_body;
   } frame_info_type;

endpackage

// ===== rtl/swmt_framer.sv =====
module swmt_framer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   output swmt_pkg::frame_info_type info
);

   logic [2:0]  pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] acc_shift;

   assign acc_shift = {acc_ff[23:0], data_byte};

   always_comb begin
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      left_in = left_ff;
      info    = '0;
      if (pos_ff >= swmt_pkg::HDR_LEN_FIRST && pos_ff <= swmt_pkg::HDR_LEN_LAST) begin
         acc_in = acc_shift;
         if (pos_ff == swmt_pkg::HDR_LEN_LAST) begin
            // A short length counts as the minimum, which leaves an empty body.
            if (acc_shift < swmt_pkg::MIN_LEN) begin
               info.err = 1'b1;
               left_in  = '0;
            end else begin
               left_in = acc_shift - swmt_pkg::MIN_LEN;
            end
            if (acc_shift <= swmt_pkg::MIN_LEN) begin
               info.last = 1'b1;
               pos_in    = swmt_pkg::HDR_KIND;
            end else begin
               info.to_body = 1'b1;
               pos_in       = swmt_pkg::HDR_BODY;
            end
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (pos_ff == swmt_pkg::HDR_BODY) begin
         info.body = 1'b1;
         if (left_ff > 32'd1) begin
            left_in = left_ff - 32'd1;
         end else begin
            left_in   = '0;
            info.last = 1'b1;
            pos_in    = swmt_pkg::HDR_KIND;
         end
      end else begin
         // Kind byte; unreachable positions fall here as well.
         info.start = 1'b1;
         acc_in     = '0;
         left_in    = '0;
         pos_in     = swmt_pkg::HDR_LEN_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= swmt_pkg::HDR_KIND;
         acc_ff  <= '0;
         left_ff <= '0;
      end else if (step) begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         left_ff <= left_in;
      end
   end

endmodule

// ===== rtl/sql_wire_message_tracker_core.sv =====
// Byte-serial tracker for a length-prefixed database wire stream.
// The req channel carries one word per byte: req_from_server picks the
// direction and req_data_byte is the next byte of that direction's stream.
// The rsp channel returns exactly one word per request word, in order, with
// the message framing flags, the query and transaction pulses, the current
// transaction flag and the two wrapping totals as they stand after the byte.
// A word is taken when valid is high and stall is low on that channel.
// From acceptance to rsp_valid the word sits in the
// input register, then the framing and counter logic loads the result register.
// Throughput is one byte per cycle; the result register frees the input
// register whenever the receiver is not stalling.
// When rsp_stall is high while a result word is valid, that word holds, the input register keeps
// its word and req_stall rises once that register is full.
// A synchronous reset returns both framers to expecting a kind byte, clears
// the transaction flag and both counters, and empties both registers.
`include "sql_wire_message_tracker_core_macros.svh"

module sql_wire_message_tracker_core #(
   parameter int COUNTER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_from_server,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_message_start,
   output logic        rsp_message_end,
   output logic        rsp_length_error,
   output logic        rsp_query_seen,
   output logic        rsp_tx_started,
   output logic        rsp_in_transaction,
   output logic [31:0] rsp_query_total,
   output logic [31:0] rsp_tx_total
);

   localparam int TotalBits = swmt_pkg::TOTAL_BITS;

   logic       in_valid_ff;
   logic       from_server_ff;
   logic [7:0] data_byte_ff;

   logic rsp_valid_ff;
   logic message_start_ff, message_end_ff, length_error_ff;
   logic query_seen_ff, tx_started_ff, in_transaction_ff;
   logic [TotalBits-1:0] query_total_ff, tx_total_ff;

   logic [7:0] server_kind_ff, server_kind_in;
   logic       first_body_ff, first_body_in;
   logic       tx_flag_ff, tx_flag_in;
   logic [COUNTER_BITS-1:0] query_count_ff, query_count_in;
   logic [COUNTER_BITS-1:0] tx_count_ff, tx_count_in;
   logic [TotalBits-1:0] query_total_in, tx_total_in;

   logic advance, fire, client_step, server_step;
   logic query_in, tx_start_in, active;
   swmt_pkg::frame_info_type client_info, server_info, info;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign client_step = fire && !from_server_ff;
   assign server_step = fire && from_server_ff;

   swmt_framer u_client_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (client_step),
      .data_byte (data_byte_ff),
      .info      (client_info)
   );

   swmt_framer u_server_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (server_step),
      .data_byte (data_byte_ff),
      .info      (server_info)
   );

   assign info   = from_server_ff ? server_info : client_info;
   assign active = (data_byte_ff != swmt_pkg::STATUS_IDLE);

   always_comb begin
      server_kind_in = server_kind_ff;
      first_body_in  = first_body_ff;
      tx_flag_in     = tx_flag_ff;
      query_count_in = query_count_ff;
      tx_count_in    = tx_count_ff;
      query_in       = 1'b0;
      tx_start_in    = 1'b0;
      if (!from_server_ff) begin
         if (client_info.start && (data_byte_ff == swmt_pkg::KIND_QUERY ||
                                   data_byte_ff == swmt_pkg::KIND_EXECUTE)) begin
            query_in       = 1'b1;
            query_count_in = query_count_ff + 1'b1;
         end
      end else if (server_info.start) begin
         server_kind_in = data_byte_ff;
         first_body_in  = 1'b0;
      end else if (server_info.to_body) begin
         first_body_in = 1'b1;
      end else if (server_info.body) begin
         // Only the first body byte of a status message carries the state.
         if (first_body_ff && server_kind_ff == swmt_pkg::KIND_STATUS) begin
            if (active && !tx_flag_ff) begin
               tx_start_in = 1'b1;
               tx_count_in = tx_count_ff + 1'b1;
            end
            tx_flag_in = active;
         end
         first_body_in = 1'b0;
      end
   end

   if (COUNTER_BITS >= TotalBits) begin : g_total_trunc
      assign query_total_in = query_count_in[TotalBits-1:0];
      assign tx_total_in    = tx_count_in[TotalBits-1:0];
   end else begin : g_total_ext
      assign query_total_in = {{(TotalBits-COUNTER_BITS){1'b0}}, query_count_in};
      assign tx_total_in    = {{(TotalBits-COUNTER_BITS){1'b0}}, tx_count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         from_server_ff <= req_from_server;
         data_byte_ff   <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_kind_ff <= '0;
         first_body_ff  <= 1'b0;
         tx_flag_ff     <= 1'b0;
         query_count_ff <= '0;
         tx_count_ff    <= '0;
      end else if (fire) begin
         server_kind_ff <= server_kind_in;
         first_body_ff  <= first_body_in;
         tx_flag_ff     <= tx_flag_in;
         query_count_ff <= query_count_in;
         tx_count_ff    <= tx_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         message_start_ff  <= info.start;
         message_end_ff    <= info.last;
         length_error_ff   <= info.err;
         query_seen_ff     <= query_in;
         tx_started_ff     <= tx_start_in;
         in_transaction_ff <= tx_flag_in;
         query_total_ff    <= query_total_in;
         tx_total_ff       <= tx_total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_message_start  = message_start_ff;
   assign rsp_message_end    = message_end_ff;
   assign rsp_length_error   = length_error_ff;
   assign rsp_query_seen     = query_seen_ff;
   assign rsp_tx_started     = tx_started_ff;
   assign rsp_in_transaction = in_transaction_ff;
   assign rsp_query_total    = query_total_ff;
   assign rsp_tx_total       = tx_total_ff;

   `SWMT_ASSERT_SAME(a_error_ends_message, clock, reset, fire && info.err, info.last,
      "short length did not end the message")
   `SWMT_ASSERT_SAME(a_start_not_last, clock, reset, fire && info.start,
      !info.last && !info.body, "kind byte also flagged as last or body")
   `SWMT_ASSERT_NEXT(a_fire_gives_word, clock, reset, fire, rsp_valid_ff,
      "accepted byte produced no result word")
   `SWMT_ASSERT_SAME(a_tx_start_sets_flag, clock, reset, rsp_valid_ff && tx_started_ff,
      in_transaction_ff && !query_seen_ff, "transaction start without transaction flag")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

   // Narrow counters exercise the zero extension of the totals.
   localparam int CNT_BITS = 8;
   localparam int QUIET_LIMIT = 5000;
   localparam int MAX_REPORTS = 10;
   localparam logic [7:0] STATUS_IN_TX = 8'h54;

   typedef struct packed {
      logic        start;
      logic        last;
      logic        err;
      logic        query;
      logic        tx_start;
      logic        in_tx;
      logic [31:0] query_total;
      logic [31:0] tx_total;
   } tracker_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_from_server = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_message_start;
   logic        rsp_message_end;
   logic        rsp_length_error;
   logic        rsp_query_seen;
   logic        rsp_tx_started;
   logic        rsp_in_transaction;
   logic [31:0] rsp_query_total;
   logic [31:0] rsp_tx_total;

   sql_wire_message_tracker_core #(
      .COUNTER_BITS(CNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_from_server(req_from_server),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_message_start(rsp_message_start),
      .rsp_message_end(rsp_message_end),
      .rsp_length_error(rsp_length_error),
      .rsp_query_seen(rsp_query_seen),
      .rsp_tx_started(rsp_tx_started),
      .rsp_in_transaction(rsp_in_transaction),
      .rsp_query_total(rsp_query_total),
      .rsp_tx_total(rsp_tx_total)
   );

   always #5 clock = ~clock;

   // Predictor state for both framers and the transaction tracking.
   logic [2:0]          cl_pos = swmt_pkg::HDR_KIND;
   logic [31:0]         cl_len = '0;
   logic [31:0]         cl_left = '0;
   logic [2:0]          sv_pos = swmt_pkg::HDR_KIND;
   logic [31:0]         sv_len = '0;
   logic [31:0]         sv_left = '0;
   logic [7:0]          sv_kind = '0;
   logic                sv_first = 1'b0;
   logic                tx_active = 1'b0;
   logic [CNT_BITS-1:0] query_count = '0;
   logic [CNT_BITS-1:0] tx_count = '0;

   tracker_word_type predicted_words[$];
   logic [7:0]       client_pending[$];
   logic [7:0]       server_pending[$];

   int bytes_sent = 0;
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;

   function automatic swmt_pkg::frame_info_type frame_byte_step(inout logic [2:0] pos,
         inout logic [31:0] acc, inout logic [31:0] left, input logic [7:0] b);
      swmt_pkg::frame_info_type fi;
      logic [31:0]              len;
      fi = '0;
      if (pos >= swmt_pkg::HDR_LEN_FIRST && pos <= swmt_pkg::HDR_LEN_LAST) begin
         acc = {acc[23:0], b};
         if (pos == swmt_pkg::HDR_LEN_LAST) begin
            len = acc;
            if (len < swmt_pkg::MIN_LEN) begin
               fi.err = 1'b1;
               len = swmt_pkg::MIN_LEN;
            end
            left = len - swmt_pkg::MIN_LEN;
            if (left == 0) begin
               fi.last = 1'b1;
               pos = swmt_pkg::HDR_KIND;
            end else begin
               fi.to_body = 1'b1;
               pos = swmt_pkg::HDR_BODY;
            end
         end else begin
            pos = pos + 3'd1;
         end
      end else if (pos == swmt_pkg::HDR_BODY) begin
         fi.body = 1'b1;
         if (left != 0) left = left - 1;
         if (left == 0) begin
            fi.last = 1'b1;
            pos = swmt_pkg::HDR_KIND;
         end
      end else begin
         fi.start = 1'b1;
         acc = '0;
         left = '0;
         pos = swmt_pkg::HDR_LEN_FIRST;
      end
      return fi;
   endfunction

   function automatic tracker_word_type predict_tracker_word(input logic srv,
         input logic [7:0] b);
      swmt_pkg::frame_info_type fi;
      tracker_word_type         w;
      w = '0;
      if (!srv) begin
         fi = frame_byte_step(cl_pos, cl_len, cl_left, b);
         if (fi.start && (b == swmt_pkg::KIND_QUERY || b == swmt_pkg::KIND_EXECUTE)) begin
            w.query = 1'b1;
            query_count = query_count + 1'b1;
         end
      end else begin
         fi = frame_byte_step(sv_pos, sv_len, sv_left, b);
         if (fi.start) begin
            sv_kind = b;
            sv_first = 1'b0;
         end else if (fi.to_body) begin
            sv_first = 1'b1;
         end else if (fi.body) begin
            // Only the first body byte of a status message carries the state.
            if (sv_first && sv_kind == swmt_pkg::KIND_STATUS) begin
               if (b != swmt_pkg::STATUS_IDLE && !tx_active) begin
                  w.tx_start = 1'b1;
                  tx_count = tx_count + 1'b1;
               end
               tx_active = (b != swmt_pkg::STATUS_IDLE);
            end
            sv_first = 1'b0;
         end
      end
      w.start = fi.start;
      w.last = fi.last;
      w.err = fi.err;
      w.in_tx = tx_active;
      w.query_total = 32'(query_count);
      w.tx_total = 32'(tx_count);
      return w;
   endfunction

   task automatic send_byte(input logic srv, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_server <= srv;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_words.push_back(predict_tracker_word(srv, b));
      bytes_sent++;
   endtask

   task automatic push_message(input logic srv, input logic [7:0] kind,
         input logic [31:0] len_field, input logic [7:0] first_body);
      logic [7:0] bytes_q[$];
      int         body_len;
      body_len = (len_field < swmt_pkg::MIN_LEN) ? 0 : int'(len_field - swmt_pkg::MIN_LEN);
      bytes_q.push_back(kind);
      bytes_q.push_back(len_field[31:24]);
      bytes_q.push_back(len_field[23:16]);
      bytes_q.push_back(len_field[15:8]);
      bytes_q.push_back(len_field[7:0]);
      for (int i = 0; i < body_len; i++)
         bytes_q.push_back((i == 0) ? first_body : 8'($urandom));
      foreach (bytes_q[i]) begin
         if (srv) server_pending.push_back(bytes_q[i]);
         else client_pending.push_back(bytes_q[i]);
      end
   endtask

   task automatic push_random_message(input logic srv);
      logic [7:0]  kind;
      logic [7:0]  first_body;
      logic [31:0] len;
      int          pick;
      pick = $urandom_range(9);
      if (srv) kind = (pick < 5) ? swmt_pkg::KIND_STATUS : 8'($urandom);
      else kind = (pick < 4) ? swmt_pkg::KIND_QUERY :
                  (pick < 6) ? swmt_pkg::KIND_EXECUTE : 8'($urandom);
      pick = $urandom_range(19);
      if (pick < 2) len = $urandom_range(3);
      else if (pick < 4) len = swmt_pkg::MIN_LEN;
      else len = swmt_pkg::MIN_LEN + $urandom_range(12);
      first_body = ($urandom_range(1) == 0) ? swmt_pkg::STATUS_IDLE : 8'($urandom);
      push_message(srv, kind, len, first_body);
   endtask

   task automatic send_pending(input logic srv);
      logic [7:0] b;
      if (srv) b = server_pending.pop_front();
      else b = client_pending.pop_front();
      send_byte(srv, b);
   endtask

   // Both directions are mixed byte by byte, so headers get split anywhere.
   task automatic drain_pending();
      while (client_pending.size() + server_pending.size() != 0) begin
         if (client_pending.size() == 0) send_pending(1'b1);
         else if (server_pending.size() == 0) send_pending(1'b0);
         else send_pending(1'($urandom_range(1)));
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_query_messages();
      push_message(1'b0, swmt_pkg::KIND_QUERY, swmt_pkg::MIN_LEN, 8'h00);
      push_message(1'b0, swmt_pkg::KIND_EXECUTE, swmt_pkg::MIN_LEN + 1, 8'hFF);
      drain_pending();
   endtask

   task automatic test_empty_status();
      push_message(1'b1, swmt_pkg::KIND_STATUS, swmt_pkg::MIN_LEN, 8'h00);
      drain_pending();
   endtask

   // A client header with a zero length field runs alongside a server
   // status word that opens a transaction.
   task automatic test_split_headers();
      push_message(1'b0, 8'h00, 32'd0, 8'h00);
      push_message(1'b1, swmt_pkg::KIND_STATUS, swmt_pkg::MIN_LEN + 1, STATUS_IN_TX);
      drain_pending();
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int first_count;
      first_count = bytes_sent;
      while (bytes_sent - first_count < n_bytes) begin
         if (client_pending.size() == 0) push_random_message(1'b0);
         if (server_pending.size() == 0) push_random_message(1'b1);
         send_pending(1'($urandom_range(1)));
      end
      drain_pending();
   endtask

   task automatic test_backpressure();
      hold_off_left = 400;
      for (int i = 0; i < 4; i++) begin
         push_random_message(1'b0);
         push_random_message(1'b1);
      end
      drain_pending();
      wait_for_results();
   endtask

   task automatic test_counter_steps();
      for (int i = 0; i < 8; i++) begin
         push_message(1'b0, swmt_pkg::KIND_QUERY, swmt_pkg::MIN_LEN, 8'h00);
         push_message(1'b1, swmt_pkg::KIND_STATUS, swmt_pkg::MIN_LEN + 1, STATUS_IN_TX);
         push_message(1'b1, swmt_pkg::KIND_STATUS, swmt_pkg::MIN_LEN + 1,
                      swmt_pkg::STATUS_IDLE);
         drain_pending();
      end
   endtask

   // Raw bytes leave the framers deep inside huge bodies, so this runs last.
   task automatic test_stream_noise();
      send_byte(1'b0, 8'h00);
      repeat (4) send_byte(1'b0, 8'hFF);
      for (int i = 0; i < 120; i++)
         send_byte(1'($urandom_range(1)), 8'($urandom));
   endtask

   always @(posedge clock) begin : response_check
      tracker_word_type got;
      tracker_word_type want;
      got = {rsp_message_start, rsp_message_end, rsp_length_error, rsp_query_seen,
             rsp_tx_started, rsp_in_transaction, rsp_query_total, rsp_tx_total};
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (predicted_words.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result word: %h", got);
         end else begin
            want = predicted_words.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"mismatch (exp/got): start %b/%b end %b/%b err %b/%b ",
                            "query %b/%b tx %b/%b in_tx %b/%b qtot %0d/%0d ",
                            "txtot %0d/%0d"},
                           want.start, got.start, want.last, got.last,
                           want.err, got.err, want.query, got.query,
                           want.tx_start, got.tx_start, want.in_tx, got.in_tx,
                           want.query_total, got.query_total,
                           want.tx_total, got.tx_total);
            end
         end
      end
      if (hold_off_left > 0) hold_off_left--;
      rsp_stall <= (hold_off_left > 0) || ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 87;
      test_query_messages();
      test_empty_status();
      test_split_headers();
      test_random_traffic(380);
      test_backpressure();
      send_idle_pct = 87;
      recv_idle_pct = 22;
      test_random_traffic(380);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(380);
      test_counter_steps();
      test_stream_noise();
      wait_for_results();
      repeat (4) @(posedge clock);
      if (error_count == 0 && predicted_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swmt_pkg.sv
rtl/swmt_framer.sv
rtl/sql_wire_message_tracker_core.sv
dv/tb_top.sv
